[sv/plti_pkg.sv]
// Shared constants, codes and types for the piecewise linear gain table.
package plti_pkg;

   // Table geometry.
   localparam int MAX_POINTS = 64;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // Field widths fixed by the interface.
   localparam int FREQ_W   = 16;
   localparam int GAIN_W   = 16;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 2;
   localparam int POINTS_W = 7;
   localparam int ENTRY_W  = FREQ_W + GAIN_W;

   // Divider sizes: a product of two 16-bit magnitudes over a 16-bit divisor.
   localparam int DIVIDEND_W = FREQ_W + GAIN_W;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

   // Item kinds.
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_INTERP = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BELOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ABOVE  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ERROR  = 2'd3;

   // Register index of the point count.
   localparam logic REG_POINTS = 1'b0;

   // Query sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_FIRST,
      S_RD_LAST,
      S_SCAN,
      S_MUL,
      S_DIV_GO,
      S_DIV_WAIT,
      S_RESULT
   } state_type;

endpackage

[sv/plti_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module plti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

[sv/plti_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module plti_div
   import plti_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [FREQ_W-1:0]     divisor,
   output logic                  done,
   output logic [GAIN_W-1:0]     quotient
);

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff;
   logic [FREQ_W:0]       rem_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [FREQ_W-1:0]     den_ff;
   logic [FREQ_W:0]       rem_sh;
   logic                  fits;

   // One restoring step: shift in the next dividend bit and try a subtract.
   always_comb begin
      rem_sh = {rem_ff[FREQ_W-1:0], quo_ff[DIVIDEND_W-1]};
      fits   = rem_sh >= {1'b0, den_ff};
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIVIDEND_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
      end
   end

   // The quotient never exceeds the gain range, so the low bits carry it all.
   assign done     = done_ff;
   assign quotient = quo_ff[GAIN_W-1:0];

endmodule

[sv/piecewise_linear_table_interp_unit.sv]
// Top level of the piecewise linear gain table with clamped ends.
// A load item writes one breakpoint into the table RAM; loads can follow
// each other in every cycle while the query sequencer is idle. A query
// item reads entry zero and the last entry in use to clamp, then scans
// segments one RAM read per cycle, then multiplies once and runs a
// bit-serial divider. The scan through the single RAM read port and the
// divider set how long a query keeps the sequencer busy; no item is
// accepted until it is done. A finished result waits in the output
// register while the next item is accepted.
module piecewise_linear_table_interp_unit
   import plti_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // Input item channel.
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  logic [INDEX_W-1:0]  req_entry_index,
   input  logic [FREQ_W-1:0]   req_point_freq,
   input  logic [GAIN_W-1:0]   req_point_gain,
   input  logic [FREQ_W-1:0]   req_query_freq,
   // Result item channel.
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [GAIN_W-1:0]   rsp_gain_out,
   output logic [STATUS_W-1:0] rsp_status,
   // Configuration port.
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   state_type state_ff, state_in;

   logic [POINTS_W-1:0] points_ff;
   logic [CNT_W-1:0]    n_ff;
   logic [CNT_W-1:0]    idx_ff;
   logic [FREQ_W-1:0]   f_ff;
   logic [FREQ_W-1:0]   pf_ff;
   logic [GAIN_W-1:0]   pg_ff;
   logic [GAIN_W-1:0]   g1_ff;
   logic [GAIN_W-1:0]   mag_ff;
   logic [FREQ_W-1:0]   off_ff;
   logic [FREQ_W-1:0]   den_ff;
   logic                neg_ff;
   logic [DIVIDEND_W-1:0] prod_ff;
   logic [GAIN_W-1:0]   res_gain_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic                rsp_valid_ff;
   logic [GAIN_W-1:0]   rsp_gain_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic                req_accept;
   logic                cfg_write;
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0]  ram_rdata;
   logic [FREQ_W-1:0]   rd_freq;
   logic [GAIN_W-1:0]   rd_gain;
   logic [CNT_W-1:0]    n_sat;
   logic                seg_hit;
   logic                div_start;
   logic                div_done;
   logic [GAIN_W-1:0]   div_q;
   logic [GAIN_W:0]     interp_sum;
   logic                rsp_free;

   // Handshakes.
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= '0;
      end else if (cfg_write && csr_paddr[2] == REG_POINTS) begin
         points_ff <= csr_pwdata[POINTS_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_POINTS) ? 32'(points_ff) : 32'd0;

   // Breakpoint table: frequency in the upper half, gain in the lower half.
   assign ram_we    = req_accept && req_kind == KIND_LOAD
                      && 32'(req_entry_index) < MAX_POINTS;
   assign ram_waddr = ADDR_W'(req_entry_index);

   plti_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata ({req_point_freq, req_point_gain}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_freq = ram_rdata[ENTRY_W-1:GAIN_W];
   assign rd_gain = ram_rdata[GAIN_W-1:0];

   // Points in use, saturated at the table size.
   assign n_sat = (32'(points_ff) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : CNT_W'(points_ff);

   // The segment from the previous entry to the one just read covers f.
   assign seg_hit = f_ff >= pf_ff && f_ff <= rd_freq;

   // Divider for the interpolation step.
   plti_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign interp_sum = neg_ff ? ({1'b0, g1_ff} - {1'b0, div_q})
                              : ({1'b0, g1_ff} + {1'b0, div_q});

   // Next state, read address and control.
   always_comb begin
      state_in  = state_ff;
      ram_raddr = '0;
      req_stall = state_ff != S_IDLE;
      div_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && req_kind == KIND_QUERY) begin
               state_in = (n_sat == '0) ? S_RESULT : S_RD_FIRST;
            end
         end
         S_RD_FIRST: begin
            ram_raddr = ADDR_W'(n_ff - 1'b1);
            state_in  = (f_ff < rd_freq) ? S_RESULT : S_RD_LAST;
         end
         S_RD_LAST: begin
            ram_raddr = ADDR_W'(1);
            if (f_ff > rd_freq || n_ff == CNT_W'(1)) begin
               state_in = S_RESULT;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            ram_raddr = ADDR_W'(idx_ff + 1'b1);
            if (seg_hit) begin
               state_in = (rd_freq == pf_ff) ? S_RESULT : S_MUL;
            end else if (idx_ff + 1'b1 == n_ff) begin
               state_in = S_RESULT;
            end
         end
         S_MUL: begin
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Query datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            f_ff          <= req_query_freq;
            n_ff          <= n_sat;
            res_gain_ff   <= '0;
            res_status_ff <= ST_ERROR;
         end
         S_RD_FIRST: begin
            pf_ff         <= rd_freq;
            pg_ff         <= rd_gain;
            res_gain_ff   <= rd_gain;
            res_status_ff <= ST_BELOW;
         end
         S_RD_LAST: begin
            idx_ff <= CNT_W'(1);
            if (f_ff > rd_freq) begin
               res_gain_ff   <= rd_gain;
               res_status_ff <= ST_ABOVE;
            end else begin
               res_gain_ff   <= pg_ff;
               res_status_ff <= ST_INTERP;
            end
         end
         S_SCAN: begin
            if (seg_hit) begin
               g1_ff         <= pg_ff;
               neg_ff        <= rd_gain < pg_ff;
               mag_ff        <= (rd_gain < pg_ff) ? (pg_ff - rd_gain) : (rd_gain - pg_ff);
               off_ff        <= f_ff - pf_ff;
               den_ff        <= rd_freq - pf_ff;
               res_gain_ff   <= pg_ff;
               res_status_ff <= ST_INTERP;
            end else begin
               pf_ff         <= rd_freq;
               pg_ff         <= rd_gain;
               idx_ff        <= idx_ff + 1'b1;
               res_gain_ff   <= '0;
               res_status_ff <= ST_ERROR;
            end
         end
         S_MUL: begin
            prod_ff <= mag_ff * off_ff;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               res_gain_ff   <= interp_sum[GAIN_W-1:0];
               res_status_ff <= ST_INTERP;
            end
         end
         default: begin
         end
      endcase
   end

   // Output register: holds a result until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_RESULT && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_RESULT && rsp_free) begin
         rsp_gain_ff   <= res_gain_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_gain_out = rsp_gain_ff;
   assign rsp_status   = rsp_status_ff;

   // An error result always carries a zero gain.
   a_error_zero_gain : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ERROR |-> rsp_gain_out == '0)
      else $error("error result with nonzero gain");

   // An accepted query always leaves the idle state.
   a_query_starts : assert property (@(posedge clock) disable iff (reset)
      req_accept && req_kind == KIND_QUERY |=> state_ff != S_IDLE)
      else $error("query accepted but sequencer stayed idle");

   // The divider finishes only while the sequencer waits for it.
   a_div_done_wait : assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV_WAIT)
      else $error("divider finished outside its wait state");

   // A load never starts the query sequencer.
   a_load_stays_idle : assert property (@(posedge clock) disable iff (reset)
      req_accept && req_kind == KIND_LOAD |=> state_ff == S_IDLE)
      else $error("load item left the idle state");

endmodule
